FILE: rtl/mer_pkg.sv
// -----------------------------------------------------------------------------
// Midpoint ellipse rasterizer package
// Shared constants, action codes and the controller/datapath command and
// status types.
// -----------------------------------------------------------------------------
package mer_pkg;

  // Colour index width and its value after reset
  localparam int unsigned COLOR_BITS  = 4;
  localparam logic [COLOR_BITS-1:0] COLOR_RESET = 4'd10;

  // One point gives four quadrant mirrors
  localparam int unsigned MIRROR_BITS = 2;
  localparam logic [MIRROR_BITS-1:0] MIRROR_FIRST = 2'd0;
  localparam logic [MIRROR_BITS-1:0] MIRROR_LAST  = 2'd3;

  // Request action codes
  localparam logic ACT_START   = 1'b0;
  localparam logic ACT_ADVANCE = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;     // capture centre and radii of a start request
    logic square;   // form rx^2 and ry^2
    logic product;  // form rx^2*ry and ry^2*rx
    logic init;     // set up region one at (0, ry)
    logic step_a;   // move the point and the slope terms
    logic step_b;   // update the decision term, flag the end
    logic advance;  // one mirrored pixel taken by the sink
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic active;     // an ellipse is in progress
    logic last_pix;   // the fourth mirror is on the output
  } status_t;

endpackage

FILE: rtl/mer_in_if.sv
// -----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one start or advance request.
// -----------------------------------------------------------------------------
interface mer_in_if #(
  parameter int unsigned RADIUS_BITS = 9,
  parameter int unsigned COORD_BITS  = 10
);

  logic                   valid;
  logic                   ready;
  logic                   action;
  logic [COORD_BITS-1:0]  center_x;
  logic [COORD_BITS-1:0]  center_y;
  logic [RADIUS_BITS-1:0] radius_x;
  logic [RADIUS_BITS-1:0] radius_y;

  modport source (output valid, action, center_x, center_y, radius_x, radius_y,
                  input ready);
  modport sink   (input valid, action, center_x, center_y, radius_x, radius_y,
                  output ready);

endinterface

FILE: rtl/mer_out_if.sv
// -----------------------------------------------------------------------------
// Pixel channel
// Valid/ready channel carrying one mirrored pixel.
// -----------------------------------------------------------------------------
interface mer_out_if #(
  parameter int unsigned COORD_BITS = 10
);
  import mer_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS+1:0] pixel_x;
  logic signed [COORD_BITS+1:0] pixel_y;
  logic [COLOR_BITS-1:0]        color;
  logic                         last_of_point;
  logic                         finished;

  modport source (output valid, pixel_x, pixel_y, color, last_of_point, finished,
                  input ready);
  modport sink   (input valid, pixel_x, pixel_y, color, last_of_point, finished,
                  output ready);

endinterface

FILE: rtl/mer_cfg_if.sv
// -----------------------------------------------------------------------------
// Colour register write channel
// Valid/ready channel carrying the pixel colour index.
// -----------------------------------------------------------------------------
interface mer_cfg_if;
  import mer_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [COLOR_BITS-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);

endinterface

FILE: rtl/mer_ctrl.sv
// -----------------------------------------------------------------------------
// Midpoint ellipse rasterizer controller
// One-hot sequencer: takes a request, walks the datapath through set-up or a
// step, then hands out the four mirrored pixels.
// -----------------------------------------------------------------------------
module mer_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_action_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  mer_pkg::status_t status_i,
  output mer_pkg::cmd_t    cmd_o
);
  import mer_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_SQUARE  = 7'b0000010,
    ST_PRODUCT = 7'b0000100,
    ST_INIT    = 7'b0001000,
    ST_STEP_A  = 7'b0010000,
    ST_STEP_B  = 7'b0100000,
    ST_EMIT    = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // Decode commands and next state
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_action_i == ACT_START) begin
            cmd_o.load = 1'b1;
            state_d    = ST_SQUARE;
          end else if (status_i.active) begin
            state_d = ST_STEP_A;
          end
        end
      end
      ST_SQUARE: begin
        cmd_o.square = 1'b1;
        state_d      = ST_PRODUCT;
      end
      ST_PRODUCT: begin
        cmd_o.product = 1'b1;
        state_d       = ST_INIT;
      end
      ST_INIT: begin
        cmd_o.init = 1'b1;
        state_d    = ST_EMIT;
      end
      ST_STEP_A: begin
        cmd_o.step_a = 1'b1;
        state_d      = ST_STEP_B;
      end
      ST_STEP_B: begin
        cmd_o.step_b = 1'b1;
        state_d      = ST_EMIT;
      end
      ST_EMIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          cmd_o.advance = 1'b1;
          if (status_i.last_pix) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold the state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/mer_dp.sv
// -----------------------------------------------------------------------------
// Midpoint ellipse rasterizer datapath
// Holds the ellipse, the current point, the slope and decision terms and the
// colour register, and forms the mirrored pixel on the output.
// -----------------------------------------------------------------------------
module mer_dp #(
  parameter int unsigned RADIUS_BITS = 9,
  parameter int unsigned COORD_BITS  = 10
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  mer_pkg::cmd_t                  cmd_i,
  output mer_pkg::status_t               status_o,
  input  logic [COORD_BITS-1:0]          center_x_i,
  input  logic [COORD_BITS-1:0]          center_y_i,
  input  logic [RADIUS_BITS-1:0]         radius_x_i,
  input  logic [RADIUS_BITS-1:0]         radius_y_i,
  input  logic                           cfg_we_i,
  input  logic [mer_pkg::COLOR_BITS-1:0] cfg_data_i,
  output logic signed [COORD_BITS+1:0]   pixel_x_o,
  output logic signed [COORD_BITS+1:0]   pixel_y_o,
  output logic [mer_pkg::COLOR_BITS-1:0] color_o,
  output logic                           last_of_point_o,
  output logic                           finished_o
);
  import mer_pkg::*;

  localparam int unsigned R   = RADIUS_BITS;
  localparam int unsigned PIX = COORD_BITS + 2;
  localparam int unsigned OW  = R + 1;            // point offsets
  localparam int unsigned SQW = 2 * R;            // squares
  localparam int unsigned PRW = 3 * R;            // cubic products
  localparam int unsigned SW  = 3 * R + 3;        // slope terms, signed
  localparam int unsigned DW  = 3 * R + 6;        // decision term, signed
  localparam int unsigned EW  = (OW > PIX) ? OW : PIX;

  // Ellipse description
  logic [COORD_BITS-1:0] cx_q, cy_q;
  logic [R-1:0]          rx_q, ry_q;
  logic [SQW-1:0]        rx2_q, ry2_q;
  logic [PRW-1:0]        prx_q, pry_q;       // rx^2*ry, ry^2*rx

  // Walk state
  logic                  active_q, region_q, switch_q, fin_q;
  logic [OW-1:0]         x_q, y_q;
  logic signed [SW-1:0]  sx_q, sy_q;
  logic signed [DW-1:0]  d_q;
  logic [MIRROR_BITS-1:0] idx_q;
  logic [COLOR_BITS-1:0] color_q;

  // Scaled constants
  logic signed [SW-1:0]  rx2_x2, ry2_x2, prx_x2, pry_x2;
  logic signed [DW-1:0]  rx2_w, ry2_w, prx_x4, pry_x4, sx_w, sy_w;
  logic signed [DW-1:0]  term;
  logic                  d_pos;

  assign rx2_x2 = $signed(SW'(rx2_q)) <<< 1;
  assign ry2_x2 = $signed(SW'(ry2_q)) <<< 1;
  assign prx_x2 = $signed(SW'(prx_q)) <<< 1;
  assign pry_x2 = $signed(SW'(pry_q)) <<< 1;
  assign rx2_w  = $signed(DW'(rx2_q));
  assign ry2_w  = $signed(DW'(ry2_q));
  assign prx_x4 = $signed(DW'(prx_q)) <<< 2;
  assign pry_x4 = $signed(DW'(pry_q)) <<< 2;
  assign sx_w   = DW'(sx_q);
  assign sy_w   = DW'(sy_q);
  assign d_pos  = !d_q[DW-1] && (d_q != '0);

  // Decision increment, quarter scale
  always_comb begin
    if (!region_q) begin
      term = d_pos ? (sx_w - sy_w + ry2_w) : (sx_w + ry2_w);
    end else begin
      term = d_pos ? (sy_w - sx_w + rx2_w) : (sy_w + rx2_w);
    end
  end

  // Capture the ellipse and form the squares and products
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cx_q <= center_x_i;
      cy_q <= center_y_i;
      rx_q <= (radius_x_i == '0) ? R'(1) : radius_x_i;
      ry_q <= (radius_y_i == '0) ? R'(1) : radius_y_i;
    end
    if (cmd_i.square) begin
      rx2_q <= SQW'(rx_q) * SQW'(rx_q);
      ry2_q <= SQW'(ry_q) * SQW'(ry_q);
    end
    if (cmd_i.product) begin
      prx_q <= PRW'(rx2_q) * PRW'(ry_q);
      pry_q <= PRW'(ry2_q) * PRW'(rx_q);
    end
  end

  // Advance the point, slopes and decision
  always_ff @(posedge clk_i) begin
    if (cmd_i.init) begin
      x_q      <= '0;
      y_q      <= OW'(ry_q);
      sx_q     <= '0;
      sy_q     <= prx_x2;
      d_q      <= (ry2_w <<< 2) - prx_x4 + rx2_w;
      switch_q <= 1'b0;
      fin_q    <= 1'b0;
    end
    if (cmd_i.step_a) begin
      switch_q <= !region_q && (sx_q > sy_q);
      if (!region_q) begin
        if (sx_q <= sy_q) begin
          x_q  <= x_q + OW'(1);
          sx_q <= sx_q + ry2_x2;
          if (d_pos) begin
            y_q  <= y_q - OW'(1);
            sy_q <= sy_q - rx2_x2;
          end
        end else begin
          // restart at (rx, 0) for region two
          x_q      <= OW'(rx_q);
          y_q      <= '0;
          sx_q     <= pry_x2;
          sy_q     <= '0;
        end
      end else begin
        y_q  <= y_q + OW'(1);
        sy_q <= sy_q + rx2_x2;
        if (d_pos) begin
          x_q  <= x_q - OW'(1);
          sx_q <= sx_q - ry2_x2;
        end
      end
    end
    if (cmd_i.step_b) begin
      if (switch_q) begin
        d_q <= (rx2_w <<< 2) - pry_x4 + ry2_w;
      end else begin
        d_q <= d_q + (term <<< 2);
      end
      fin_q <= region_q && !(sx_q > sy_q);
    end
  end

  // Control flags, mirror counter and colour register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      region_q <= 1'b0;
      idx_q    <= MIRROR_FIRST;
      color_q  <= COLOR_RESET;
    end else begin
      if (cmd_i.init) begin
        active_q <= 1'b1;
        region_q <= 1'b0;
      end
      if (cmd_i.step_a && !region_q && !(sx_q <= sy_q)) begin
        region_q <= 1'b1;
      end
      if (cmd_i.step_b && region_q && !(sx_q > sy_q)) begin
        active_q <= 1'b0;
      end
      if (cmd_i.advance) begin
        idx_q <= idx_q + MIRROR_BITS'(1);
      end
      if (cfg_we_i) begin
        color_q <= cfg_data_i;
      end
    end
  end

  // Mirror the point about the centre
  logic [EW-1:0]  off_x_e, off_y_e;
  logic [PIX-1:0] off_x, off_y, cen_x, cen_y;

  assign off_x_e = EW'(x_q);
  assign off_y_e = EW'(y_q);
  assign off_x   = off_x_e[PIX-1:0];
  assign off_y   = off_y_e[PIX-1:0];
  assign cen_x   = PIX'(cx_q);
  assign cen_y   = PIX'(cy_q);

  assign pixel_x_o       = $signed(idx_q[0] ? (cen_x - off_x) : (cen_x + off_x));
  assign pixel_y_o       = $signed(idx_q[1] ? (cen_y - off_y) : (cen_y + off_y));
  assign color_o         = color_q;
  assign last_of_point_o = (idx_q == MIRROR_LAST);
  assign finished_o      = fin_q;

  assign status_o.active   = active_q;
  assign status_o.last_pix = (idx_q == MIRROR_LAST);

endmodule

FILE: rtl/midpoint_ellipse_rasterizer_top.sv
// -----------------------------------------------------------------------------
// Midpoint ellipse rasterizer
// Start and advance requests walk one quadrant of an ellipse by the midpoint
// method and give four mirrored pixels per point.
//
//   channel   dir   carries                                   accepted when
//   in_ch     in    action, center_x/y, radius_x/y            valid && ready
//   out_ch    out   pixel_x/y, color, last_of_point, finished valid && ready
//   cfg_ch    in    data (pixel colour index)                 valid && ready
//
// A start request runs the square, product and set-up steps, then gives four
// pixels; an advance runs two update steps, then gives four pixels; an advance
// with no ellipse in progress gives nothing.
// The four pixels leave one per cycle from the point registers; a stalled
// sink holds them and no new request is taken until the fourth has gone.
// Reset clears the sequencer, the active and region flags and the mirror counter and sets colour 10.
// -----------------------------------------------------------------------------
module midpoint_ellipse_rasterizer_top #(
  parameter int unsigned RADIUS_BITS = 9,
  parameter int unsigned COORD_BITS  = 10
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mer_in_if.sink    in_ch,
  mer_out_if.source out_ch,
  mer_cfg_if.sink   cfg_ch
);
  import mer_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Colour writes are always taken
  assign cfg_ch.ready = 1'b1;

  mer_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_action_i (in_ch.action),
    .in_ready_o  (in_ch.ready),
    .out_valid_o (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  mer_dp #(
    .RADIUS_BITS (RADIUS_BITS),
    .COORD_BITS  (COORD_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .center_x_i      (in_ch.center_x),
    .center_y_i      (in_ch.center_y),
    .radius_x_i      (in_ch.radius_x),
    .radius_y_i      (in_ch.radius_y),
    .cfg_we_i        (cfg_ch.valid && cfg_ch.ready),
    .cfg_data_i      (cfg_ch.data),
    .pixel_x_o       (out_ch.pixel_x),
    .pixel_y_o       (out_ch.pixel_y),
    .color_o         (out_ch.color),
    .last_of_point_o (out_ch.last_of_point),
    .finished_o      (out_ch.finished)
  );

  // No request is taken while pixels are pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid |-> !in_ch.ready)
    else $error("request taken while pixels pending");

  // The fourth pixel leaving returns the block to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && out_ch.ready && out_ch.last_of_point) |=> in_ch.ready)
    else $error("block not idle after last pixel");

  // An advance with no ellipse gives no pixel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ch.valid && in_ch.ready && in_ch.action == ACT_ADVANCE && !status.active)
      |=> (in_ch.ready && !out_ch.valid))
    else $error("idle advance produced work");

  // A finished point leaves no ellipse in progress
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && out_ch.finished) |-> !status.active)
    else $error("ellipse still active after finishing point");

endmodule
